// ===== rtl/request_queue_dispatcher_defines.svh =====
// Assertion macros for the request queue dispatcher.
// Expects clk and rst_n in the including scope.
`ifndef REQUEST_QUEUE_DISPATCHER_DEFINES_SVH
`define REQUEST_QUEUE_DISPATCHER_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define RQD_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that, when true, forces another in the same cycle.
`define RQD_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rqd_pkg.sv =====
// Shared types and constants for the request queue dispatcher.
// No dependencies.
`default_nettype none
package rqd_pkg;

    typedef struct packed {
        logic [31:0] host;
        logic [15:0] port;
        logic [31:0] tx_secs;
        logic [31:0] tx_frac;
        logic [62:0] read_stamp;
        logic [31:0] stamp;
    } entry_t;

    typedef struct packed {
        logic search;
        logic pop;
        logic insert;
    } chain_ctl_t;

    typedef struct packed {
        logic head_valid;
        logic top_valid;
        logic any_hit;
    } chain_sts_t;

    localparam logic [1:0] CMD_ARRIVE = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    localparam logic [1:0] KIND_ARRIVAL  = 2'd0;
    localparam logic [1:0] KIND_DISPATCH = 2'd1;
    localparam logic [1:0] KIND_POLL     = 2'd2;
    localparam logic [1:0] KIND_ACK      = 2'd3;

    localparam logic [1:0] STAT_QUEUED   = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_REJECTED = 2'd2;

    localparam logic [1:0] REG_QUEUE_LIMIT = 2'd0;
    localparam logic [1:0] REG_MAX_AGE     = 2'd1;
    localparam logic [1:0] REG_MAX_WORKERS = 2'd2;

    localparam logic [7:0]  MODE_REQUEST = 8'h23;
    localparam logic [15:0] MIN_LENGTH   = 16'd48;
    localparam logic [7:0]  MS_IDLE      = 8'd11;
    localparam logic [7:0]  MS_BUSY      = 8'd55;
    localparam logic [7:0]  MS_SATURATED = 8'd111;
    localparam logic [5:0]  MAX_DISPATCH = 6'd63;

    localparam logic [10:0] RST_QUEUE_LIMIT = 11'd1000;
    localparam logic [7:0]  RST_MAX_AGE     = 8'd25;
    localparam logic [5:0]  RST_MAX_WORKERS = 6'd50;

endpackage
`default_nettype wire

// ===== rtl/rqd_cell.sv =====
// One queue cell: holds an entry, drops it on a key hit or pop, lets it fall
// toward the head when the cell below is open. Uses rqd_pkg.
`default_nettype none
module rqd_cell
    import rqd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        search,
    input  wire logic [31:0] key_host,
    input  wire logic [15:0] key_port,
    input  wire logic        pop,
    input  wire logic        insert,
    input  wire entry_t      insert_data,
    input  wire logic        lower_open,
    input  wire logic        upper_avail,
    input  wire entry_t      upper_data,
    output logic             avail,
    output logic             open,
    output logic             valid,
    output logic             hit,
    output entry_t           data
);

    logic   valid_reg, valid_next;
    entry_t data_reg, data_next;

    assign hit   = search && valid_reg && (data_reg.host == key_host)
                   && (data_reg.port == key_port);
    assign avail = valid_reg && !hit && !pop;
    assign open  = !avail;
    assign valid = valid_reg;
    assign data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (avail)
        begin
            valid_next = !lower_open;
        end
        else if (insert)
        begin
            valid_next = 1'b1;
            data_next  = insert_data;
        end
        else
        begin
            valid_next = upper_avail;
            data_next  = upper_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule
`default_nettype wire

// ===== rtl/rqd_chain.sv =====
// Row of queue cells, head at cell 0, arrivals enter at the top cell.
// Key hits are gathered by a two-level registered OR. Uses rqd_pkg, rqd_cell.
`default_nettype none
module rqd_chain
    import rqd_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire chain_ctl_t  ctl,
    input  wire logic [31:0] key_host,
    input  wire logic [15:0] key_port,
    input  wire entry_t      insert_data,
    output entry_t           head_data,
    output chain_sts_t       sts
);

    localparam int GROUPS = (DEPTH + 31) / 32;

    logic   avail [DEPTH];
    logic   open  [DEPTH];
    logic   valid [DEPTH];
    entry_t data  [DEPTH];
    logic [GROUPS*32-1:0] hits;
    logic [GROUPS-1:0]    group_hit_reg;
    logic                 any_hit_reg;

    genvar i;
    generate
        for (i = 0; i < GROUPS * 32; i++)
        begin : g_pad
            if (i >= DEPTH)
            begin : g_zero
                assign hits[i] = 1'b0;
            end
        end
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic   lower_open;
            logic   upper_avail;
            entry_t upper_data;
            if (i == 0)
            begin : g_head
                assign lower_open = 1'b0;
            end
            else
            begin : g_body
                assign lower_open = open[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_top
                assign upper_avail = 1'b0;
                assign upper_data  = insert_data;
            end
            else
            begin : g_mid
                assign upper_avail = avail[i+1];
                assign upper_data  = data[i+1];
            end
            rqd_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .search      (ctl.search),
                .key_host    (key_host),
                .key_port    (key_port),
                .pop         ((i == 0) ? ctl.pop : 1'b0),
                .insert      ((i == DEPTH - 1) ? ctl.insert : 1'b0),
                .insert_data (insert_data),
                .lower_open  (lower_open),
                .upper_avail (upper_avail),
                .upper_data  (upper_data),
                .avail       (avail[i]),
                .open        (open[i]),
                .valid       (valid[i]),
                .hit         (hits[i]),
                .data        (data[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_hit_reg <= '0;
            any_hit_reg   <= 1'b0;
        end
        else
        begin
            for (int g = 0; g < GROUPS; g++)
            begin
                group_hit_reg[g] <= |hits[g*32 +: 32];
            end
            any_hit_reg <= |group_hit_reg;
        end
    end

    assign head_data      = data[0];
    assign sts.head_valid = valid[0];
    assign sts.top_valid  = valid[DEPTH-1];
    assign sts.any_hit    = any_hit_reg;

endmodule
`default_nettype wire

// ===== rtl/request_queue_dispatcher.sv =====
// Channel | handshake            | payload
// in      | in_valid / in_stall  | command, host_addr, port, mode_byte, packet_length,
//         |                      | tx_secs, tx_frac, read_stamp, now_secs
// out     | out_valid / out_stall| kind, status, out_host, out_port, out_tx_secs,
//         |                      | out_tx_frac, out_read_stamp, interval_ms, last
// cfg     | cfg_we               | cfg_index, cfg_data
// One item at a time; in_stall is high from acceptance until its final result is loaded.
// Arrival: search (SRCH, HIT1, HIT2), then admission (ADM); full or rejected goes to RES,
// queued waits in INS for the top cell to empty (entries fall one cell a cycle).
// Tick: pops stale head entries and dispatches the rest up to MAX_DISPATCH, waiting for
// entries to reach the head cell. Output stalls hold the sequencer.
// Reset clears control state only; no clearing pass.
// Top level: sequencer and config; depends on rqd_pkg, rqd_chain, defines header.
`default_nettype none
`include "request_queue_dispatcher_defines.svh"
module request_queue_dispatcher
    import rqd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 1024
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  command,
    input  wire logic [31:0] host_addr,
    input  wire logic [15:0] port,
    input  wire logic [7:0]  mode_byte,
    input  wire logic [15:0] packet_length,
    input  wire logic [31:0] tx_secs,
    input  wire logic [31:0] tx_frac,
    input  wire logic [62:0] read_stamp,
    input  wire logic [31:0] now_secs,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [1:0]       status,
    output logic [31:0]      out_host,
    output logic [15:0]      out_port,
    output logic [31:0]      out_tx_secs,
    output logic [31:0]      out_tx_frac,
    output logic [62:0]      out_read_stamp,
    output logic [7:0]       interval_ms,
    output logic             last,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int LW = (CW > 11) ? CW : 11;
    localparam logic [LW-1:0] DEPTH_L = LW'(QUEUE_DEPTH);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SRCH = 4'd1;
    localparam logic [3:0] ST_HIT1 = 4'd2;
    localparam logic [3:0] ST_HIT2 = 4'd3;
    localparam logic [3:0] ST_ADM  = 4'd4;
    localparam logic [3:0] ST_INS  = 4'd5;
    localparam logic [3:0] ST_RES  = 4'd6;
    localparam logic [3:0] ST_TICK = 4'd7;
    localparam logic [3:0] ST_POLL = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic [10:0]   limit_cfg_reg;
    logic [7:0]    max_age_reg;
    logic [5:0]    max_workers_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [5:0]    active_reg, active_next;
    logic          busy_reg, busy_next;
    logic          was_full_reg, was_full_next;
    logic [31:0]   last_check_reg, last_check_next;
    logic [5:0]    n_reg, n_next;
    logic [1:0]    res_kind_reg, res_kind_next;
    logic [1:0]    res_status_reg, res_status_next;

    logic [31:0]   host_reg;
    logic [15:0]   port_reg;
    logic [7:0]    mode_reg;
    logic [15:0]   len_reg;
    logic [31:0]   txs_reg;
    logic [31:0]   txf_reg;
    logic [62:0]   rd_reg;

    logic          out_valid_reg, out_valid_next;
    logic [1:0]    kind_reg, kind_next;
    logic [1:0]    status_reg, status_next;
    entry_t        out_entry_reg, out_entry_next;
    logic [7:0]    interval_reg, interval_next;
    logic          last_reg, last_next;

    chain_ctl_t    ctl;
    chain_sts_t    sts;
    entry_t        head_data;
    entry_t        insert_data;
    logic          out_free;
    logic          accept;
    logic [LW-1:0] limit;
    logic [32:0]   age;
    logic          stale;
    logic          saturated;
    logic [7:0]    ms_base;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign limit = (LW'(limit_cfg_reg) > DEPTH_L) ? DEPTH_L : LW'(limit_cfg_reg);
    assign age   = {1'b0, last_check_reg} - {1'b0, head_data.stamp};
    assign stale = !age[32] && (age[31:0] > {24'd0, max_age_reg});
    assign saturated = (active_reg >= max_workers_reg);
    assign ms_base   = busy_reg ? MS_SATURATED : MS_BUSY;

    assign insert_data = '{host: host_reg, port: port_reg, tx_secs: txs_reg,
                           tx_frac: txf_reg, read_stamp: rd_reg, stamp: last_check_reg};

    rqd_chain #(.DEPTH(QUEUE_DEPTH)) u_chain (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .key_host    (host_reg),
        .key_port    (port_reg),
        .insert_data (insert_data),
        .head_data   (head_data),
        .sts         (sts)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        active_next     = active_reg;
        busy_next       = busy_reg;
        was_full_next   = was_full_reg;
        last_check_next = last_check_reg;
        n_next          = n_reg;
        res_kind_next   = res_kind_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        kind_next       = kind_reg;
        status_next     = status_reg;
        out_entry_next  = out_entry_reg;
        interval_next   = interval_reg;
        last_next       = last_reg;
        ctl             = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        CMD_ARRIVE:
                        begin
                            state_next = ST_SRCH;
                        end
                        CMD_TICK:
                        begin
                            last_check_next = now_secs;
                            was_full_next   = saturated;
                            n_next          = '0;
                            state_next      = ST_TICK;
                        end
                        CMD_FINISH:
                        begin
                            if (active_reg != '0)
                            begin
                                active_next = active_reg - 6'd1;
                            end
                            res_kind_next   = KIND_ACK;
                            res_status_next = STAT_QUEUED;
                            state_next      = ST_RES;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SRCH:
            begin
                ctl.search = 1'b1;
                state_next = ST_HIT1;
            end
            ST_HIT1:
            begin
                state_next = ST_HIT2;
            end
            ST_HIT2:
            begin
                if (sts.any_hit)
                begin
                    count_next = count_reg - CW'(1);
                end
                state_next = ST_ADM;
            end
            ST_ADM:
            begin
                res_kind_next = KIND_ARRIVAL;
                if (LW'(count_reg) >= limit)
                begin
                    res_status_next = STAT_FULL;
                    state_next      = ST_RES;
                end
                else if (len_reg < MIN_LENGTH || mode_reg != MODE_REQUEST || txs_reg == '0)
                begin
                    res_status_next = STAT_REJECTED;
                    state_next      = ST_RES;
                end
                else
                begin
                    state_next = ST_INS;
                end
            end
            ST_INS:
            begin
                if (!sts.top_valid)
                begin
                    ctl.insert      = 1'b1;
                    count_next      = count_reg + CW'(1);
                    res_status_next = STAT_QUEUED;
                    state_next      = ST_RES;
                end
            end
            ST_RES:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = res_kind_reg;
                    status_next    = res_status_reg;
                    out_entry_next = '0;
                    interval_next  = '0;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                if (!saturated && count_reg != '0)
                begin
                    if (sts.head_valid)
                    begin
                        if (stale)
                        begin
                            ctl.pop    = 1'b1;
                            count_next = count_reg - CW'(1);
                        end
                        else if (n_reg == MAX_DISPATCH)
                        begin
                            state_next = ST_POLL;
                        end
                        else if (out_free)
                        begin
                            ctl.pop        = 1'b1;
                            count_next     = count_reg - CW'(1);
                            active_next    = active_reg + 6'd1;
                            n_next         = n_reg + 6'd1;
                            out_valid_next = 1'b1;
                            kind_next      = KIND_DISPATCH;
                            status_next    = STAT_QUEUED;
                            out_entry_next = head_data;
                            interval_next  = '0;
                            last_next      = 1'b0;
                        end
                    end
                end
                else
                begin
                    state_next = ST_POLL;
                end
            end
            ST_POLL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_POLL;
                    status_next    = STAT_QUEUED;
                    out_entry_next = '0;
                    last_next      = 1'b1;
                    if (saturated)
                    begin
                        interval_next = was_full_reg ? {ms_base[6:0], 1'b0} : ms_base;
                        busy_next     = 1'b1;
                    end
                    else
                    begin
                        interval_next = MS_IDLE;
                        busy_next     = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            limit_cfg_reg   <= RST_QUEUE_LIMIT;
            max_age_reg     <= RST_MAX_AGE;
            max_workers_reg <= RST_MAX_WORKERS;
            count_reg       <= '0;
            active_reg      <= '0;
            busy_reg        <= 1'b0;
            was_full_reg    <= 1'b0;
            last_check_reg  <= '0;
            n_reg           <= '0;
            res_kind_reg    <= KIND_ARRIVAL;
            res_status_reg  <= STAT_QUEUED;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            active_reg     <= active_next;
            busy_reg       <= busy_next;
            was_full_reg   <= was_full_next;
            last_check_reg <= last_check_next;
            n_reg          <= n_next;
            res_kind_reg   <= res_kind_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_QUEUE_LIMIT: limit_cfg_reg   <= cfg_data;
                    REG_MAX_AGE:     max_age_reg     <= cfg_data[7:0];
                    REG_MAX_WORKERS: max_workers_reg <= cfg_data[5:0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            host_reg <= host_addr;
            port_reg <= port;
            mode_reg <= mode_byte;
            len_reg  <= packet_length;
            txs_reg  <= tx_secs;
            txf_reg  <= tx_frac;
            rd_reg   <= read_stamp;
        end
        kind_reg      <= kind_next;
        status_reg    <= status_next;
        out_entry_reg <= out_entry_next;
        interval_reg  <= interval_next;
        last_reg      <= last_next;
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign status         = status_reg;
    assign out_host       = out_entry_reg.host;
    assign out_port       = out_entry_reg.port;
    assign out_tx_secs    = out_entry_reg.tx_secs;
    assign out_tx_frac    = out_entry_reg.tx_frac;
    assign out_read_stamp = out_entry_reg.read_stamp;
    assign interval_ms    = interval_reg;
    assign last           = last_reg;

    `RQD_ALWAYS(a_count_bound, LW'(count_reg) <= DEPTH_L, "queue count above depth")
    `RQD_IMPLIES(a_empty_head, count_reg == '0, !sts.head_valid, "entry held with zero count")
    `RQD_IMPLIES(a_insert_top, ctl.insert, !sts.top_valid, "insert into occupied top cell")
    `RQD_IMPLIES(a_pop_head, ctl.pop, sts.head_valid, "pop from empty head cell")

endmodule
`default_nettype wire
